// ===== design/rcg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcg_pkg: shared types and constants of the rolling cost grid
// Sizes, opcodes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package rcg_pkg;
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned XW = $clog2(MaxWidth);
  localparam int unsigned YW = $clog2(MaxHeight);
  localparam int unsigned AW = XW + YW;
  localparam int unsigned DEPTH = MaxWidth * MaxHeight;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SHIFT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RES    = 2'd2,
    REG_DEF    = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_RDWAIT, ST_CLEAR, ST_DIV, ST_MUL, ST_SWEEP_RD, ST_SWEEP_WR,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        start;
    logic        sgn;
    logic [32:0] mag;
  } div_req_t;
endpackage

// ===== design/rcg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcg_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module rcg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== design/rcg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcg_div: serial restoring divider
// Divides a 33-bit magnitude by a 31-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rcg_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rcg_pkg::div_req_t req_i,
  input  logic [30:0]      den_i,
  output logic             done_o,
  output logic [33:0]      quo_o
);
  import rcg_pkg::*;

  logic [32:0] q_q, q_d;
  logic [31:0] r_q, r_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, sgn_q, sgn_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    q_d = q_q;
    r_d = r_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    sgn_d = sgn_q;
    done_d = busy_q && (cnt_q == 6'd1);
    trial = {r_q, q_q[32]};
    if (req_i.start) begin
      q_d = req_i.mag;
      r_d = '0;
      cnt_d = 6'd33;
      busy_d = 1'b1;
      sgn_d = req_i.sgn;
    end else if (busy_q) begin
      if (trial >= {2'b0, den_i}) begin
        r_d = 32'(trial - {2'b0, den_i});
        q_d = {q_q[31:0], 1'b1};
      end else begin
        r_d = trial[31:0];
        q_d = {q_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    sgn_q <= sgn_d;
  end

  assign done_o = done_q;
  assign quo_o = sgn_q ? 34'(-$signed({1'b0, q_q})) : {1'b0, q_q};
endmodule

// ===== design/rolling_cost_grid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_cost_grid: rolling window of 8-bit cell costs
// Reads, writes, clears rectangles and shifts the window origin.
// ----------------------------------------------------------------------------
// A command word enters on s_axis; one result word per command leaves on
// m_axis. Configuration is written on the cfg channel while idle or during the reset sweep.
// After reset the block sweeps all 65536 cells to zero, one per cycle, and
// accepts no command during that pass.
// Read: ST_RDWAIT captures the RAM data, then ST_OUT. Write: the cell is
// written as the command is taken. Clear: writes each cell of the clipped
// rectangle in turn. Shift: two serial divisions, two serial multiplies,
// then each used cell is read then written (one RAM port) to move the window.
// One command is in flight at a time; s_axis_tready is low while it works
// and while a result waits. A stalled receiver holds the result word.
// ----------------------------------------------------------------------------
module rolling_cost_grid (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[1:0] cell_x[9:2] cell_y[17:10] end_x[26:18] end_y[35:27]
  // write_cost[43:36] origin_x_in[75:44] origin_y_in[107:76], zero to 111
  input  logic [111:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_cost[7:0] out_of_range[8], zero to 15
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import rcg_pkg::*;

  state_e state_q, state_d;
  logic [8:0]  gw_q, gh_q;
  logic [30:0] res_q;
  logic [7:0]  def_q;
  logic signed [31:0] ox_q, oy_q, ox_d, oy_d;

  logic [1:0]  op_q;
  logic [8:0]  cx_q, ex_q, ey_q;
  logic signed [31:0] ny_q;
  logic [7:0]  rd_q, rd_d;
  logic        oor_q, oor_d;

  logic [8:0]  x_q, x_d, y_q, y_d, i_q, i_d, j_q, j_d;
  logic [16:0] init_q, init_d;
  logic        axis_q, axis_d;
  logic signed [33:0] dx_q, dx_d, dy_q, dy_d;

  // serial multiply: acc += d*res, one bit of res per cycle
  logic signed [65:0] acc_q, acc_d;
  logic [5:0]  mc_q, mc_d;

  logic [8:0]  w, h;
  logic [30:0] res;
  logic        we;
  logic [AW-1:0] addr;
  logic [7:0]  wdata, rdata;
  div_req_t    dreq;
  logic        ddone;
  logic [33:0] dquo;

  assign w = (gw_q == 9'd0) ? 9'd1 : (gw_q > 9'(MaxWidth)) ? 9'(MaxWidth) : gw_q;
  assign h = (gh_q == 9'd0) ? 9'd1 : (gh_q > 9'(MaxHeight)) ? 9'(MaxHeight) : gh_q;
  assign res = (res_q == 31'd0) ? 31'd1 : res_q;

  logic signed [32:0] diff;
  logic signed [33:0] sx, sy;
  logic [8:0] xc, yc, xe, ye;
  assign xe = (ex_q > w) ? w : ex_q;
  assign ye = (ey_q > h) ? h : ey_q;

  always_comb begin
    xc = dx_q[33] ? 9'(w - 9'd1 - j_q) : j_q;
    yc = dy_q[33] ? 9'(h - 9'd1 - i_q) : i_q;
    sx = 34'($signed({25'd0, xc})) + dx_q;
    sy = 34'($signed({25'd0, yc})) + dy_q;
  end

  rcg_ram #(.Width(8), .Depth(DEPTH)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  rcg_div u_div (
    .clk_i, .rst_ni, .req_i(dreq), .den_i(res), .done_o(ddone), .quo_o(dquo)
  );

  assign cfg_ready_o = (state_q == ST_IDLE) || (state_q == ST_INIT);
  assign s_axis_tready = (state_q == ST_IDLE) && !m_axis_tvalid;
  assign m_axis_tdata = {7'd0, oor_q, rd_q};

  always_comb begin
    state_d = state_q;
    we = 1'b0;
    addr = {y_q[YW-1:0], x_q[XW-1:0]};
    wdata = def_q;
    rd_d = rd_q;
    oor_d = oor_q;
    x_d = x_q; y_d = y_q; i_d = i_q; j_d = j_q;
    init_d = init_q;
    axis_d = axis_q;
    dx_d = dx_q; dy_d = dy_q;
    ox_d = ox_q; oy_d = oy_q;
    acc_d = acc_q; mc_d = mc_q;
    dreq = '0;
    diff = '0;
    unique case (state_q)
      ST_INIT: begin
        we = 1'b1;
        addr = init_q[AW-1:0];
        wdata = '0;
        init_d = init_q + 17'd1;
        if (init_q == 17'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: ;
      ST_RDWAIT: begin
        rd_d = rdata;
        state_d = ST_OUT;
      end
      ST_CLEAR: begin
        if (y_q >= ye || x_q >= xe) begin
          state_d = ST_OUT;
        end else begin
          we = 1'b1;
          if (x_q + 9'd1 >= xe) begin
            x_d = cx_q;
            y_d = y_q + 9'd1;
          end else begin
            x_d = x_q + 9'd1;
          end
        end
      end
      ST_DIV: begin
        if (ddone) begin
          if (!axis_q) begin
            dx_d = $signed(dquo);
            axis_d = 1'b1;
            diff = 33'(ny_q) - 33'(oy_q);
            dreq.start = 1'b1;
            dreq.sgn = diff[32];
            dreq.mag = diff[32] ? 33'(-diff) : 33'(diff);
          end else begin
            dy_d = $signed(dquo);
            axis_d = 1'b0;
            acc_d = '0;
            mc_d = '0;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (res[mc_q[4:0]]) begin
          acc_d = acc_q + ((axis_q ? 66'(dy_q) : 66'(dx_q)) <<< mc_q[4:0]);
        end
        mc_d = mc_q + 6'd1;
        if (mc_q == 6'd30) begin
          acc_d = acc_d + 66'(axis_q ? oy_q : ox_q);
          if (acc_d > 66'sd2147483647) begin
            acc_d = 66'sd2147483647;
          end else if (acc_d < -66'sd2147483648) begin
            acc_d = -66'sd2147483648;
          end
          if (!axis_q) begin
            ox_d = 32'(acc_d);
            axis_d = 1'b1;
            acc_d = '0;
            mc_d = '0;
          end else begin
            oy_d = 32'(acc_d);
            axis_d = 1'b0;
            i_d = '0; j_d = '0;
            state_d = ST_SWEEP_RD;
          end
        end
      end
      ST_SWEEP_RD: begin
        addr = {sy[YW-1:0], sx[XW-1:0]};
        state_d = ST_SWEEP_WR;
      end
      ST_SWEEP_WR: begin
        we = 1'b1;
        addr = {yc[YW-1:0], xc[XW-1:0]};
        wdata = (sx >= 0 && sx < 34'($signed({25'd0, w})) && sy >= 0 &&
                 sy < 34'($signed({25'd0, h}))) ? rdata : def_q;
        state_d = ST_SWEEP_RD;
        if (j_q + 9'd1 >= w) begin
          j_d = '0;
          i_d = i_q + 9'd1;
          if (i_q + 9'd1 >= h) begin
            state_d = ST_OUT;
          end
        end else begin
          j_d = j_q + 9'd1;
        end
      end
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase

    if (s_axis_tvalid && s_axis_tready) begin
      rd_d = '0;
      oor_d = 1'b0;
      x_d = {1'b0, s_axis_tdata[9:2]};
      y_d = {1'b0, s_axis_tdata[17:10]};
      unique case (op_e'(s_axis_tdata[1:0]))
        OP_READ, OP_WRITE: begin
          addr = {s_axis_tdata[10 +: YW], s_axis_tdata[2 +: XW]};
          if ({1'b0, s_axis_tdata[9:2]} >= w || {1'b0, s_axis_tdata[17:10]} >= h) begin
            oor_d = 1'b1;
            state_d = ST_OUT;
          end else if (s_axis_tdata[1:0] == OP_WRITE) begin
            we = 1'b1;
            wdata = s_axis_tdata[43:36];
            state_d = ST_OUT;
          end else begin
            state_d = ST_RDWAIT;
          end
        end
        OP_CLEAR: begin
          oor_d = (s_axis_tdata[26:18] > w) || (s_axis_tdata[35:27] > h);
          state_d = ST_CLEAR;
        end
        OP_SHIFT: begin
          diff = 33'($signed(s_axis_tdata[75:44])) - 33'(ox_q);
          dreq.start = 1'b1;
          dreq.sgn = diff[32];
          dreq.mag = diff[32] ? 33'(-diff) : 33'(diff);
          axis_d = 1'b0;
          state_d = ST_DIV;
        end
        default: state_d = ST_OUT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      init_q <= '0;
      gw_q <= 9'd256;
      gh_q <= 9'd256;
      res_q <= 31'd3277;
      def_q <= '0;
      ox_q <= '0;
      oy_q <= '0;
      m_axis_tvalid <= 1'b0;
      axis_q <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q <= init_d;
      ox_q <= ox_d;
      oy_q <= oy_d;
      axis_q <= axis_d;
      if (state_q == ST_OUT) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (reg_e'(cfg_index_i))
          REG_WIDTH:  gw_q <= cfg_data_i[8:0];
          REG_HEIGHT: gh_q <= cfg_data_i[8:0];
          REG_RES:    res_q <= cfg_data_i[30:0];
          REG_DEF:    def_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= rd_d;
    oor_q <= oor_d;
    x_q <= x_d; y_q <= y_d; i_q <= i_d; j_q <= j_d;
    dx_q <= dx_d; dy_q <= dy_d;
    acc_q <= acc_d; mc_q <= mc_d;
    if (s_axis_tvalid && s_axis_tready) begin
      op_q <= s_axis_tdata[1:0];
      cx_q <= {1'b0, s_axis_tdata[9:2]};
      ex_q <= s_axis_tdata[26:18];
      ey_q <= s_axis_tdata[35:27];
      ny_q <= s_axis_tdata[107:76];
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_shift_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && op_q == OP_SHIFT) |-> (rd_q == 8'd0 && !oor_q))
    else $error("shift result not zero");
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for rolling_cost_grid
// Drives command words with random idling and receiver stalls, predicts each
// result word from a local copy of the grid, origin and registers, and
// compares read_cost and out_of_range in order.
// ----------------------------------------------------------------------------
module tb;
  import rcg_pkg::*;

  typedef struct packed {
    logic [31:0] oy;
    logic [31:0] ox;
    logic [7:0]  wc;
    logic [8:0]  ey;
    logic [8:0]  ex;
    logic [7:0]  cy;
    logic [7:0]  cx;
    op_e         op;
  } cmd_t;

  typedef struct packed {
    logic       oor;
    logic [7:0] cost;
  } res_t;

  typedef struct {
    cmd_t cmd;
    logic chk;
    res_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rolling_cost_grid DUT (.*);

  // model state
  logic [7:0] grid_q [0:DEPTH-1];
  logic [7:0] tmp_grid [0:DEPTH-1];
  longint org_x, org_y;
  logic [8:0] width_q, height_q;
  logic [30:0] res_q;
  logic [7:0] def_q;

  res_t expected_q[$];
  int fails = 0;
  int words_out = 0;
  int idle_pct = 0, stall_pct = 0;
  int hold_off = 0;
  int quiet = 0;
  int n_shift = 0, n_clear = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint div_tz(longint num, longint den);
    longint m;
    m = num < 0 ? -num : num;
    return num < 0 ? -(m / den) : m / den;
  endfunction

  task automatic predict_cost(input cmd_t c, output res_t r);
    int w, h, xe, ye, sx, sy;
    longint dx, dy, den;
    w = width_q == 0 ? 1 : (width_q > MaxWidth ? MaxWidth : width_q);
    h = height_q == 0 ? 1 : (height_q > MaxHeight ? MaxHeight : height_q);
    r = '0;
    case (c.op)
      OP_READ, OP_WRITE: begin
        if (c.cx >= w || c.cy >= h) r.oor = 1'b1;
        else if (c.op == OP_READ) r.cost = grid_q[c.cy * MaxWidth + c.cx];
        else grid_q[c.cy * MaxWidth + c.cx] = c.wc;
      end
      OP_CLEAR: begin
        xe = c.ex > w ? w : c.ex;
        ye = c.ey > h ? h : c.ey;
        r.oor = c.ex > w || c.ey > h;
        for (int y = c.cy; y < ye; y++)
          for (int x = c.cx; x < xe; x++) grid_q[y * MaxWidth + x] = def_q;
      end
      default: begin
        den = res_q == 0 ? 1 : longint'(res_q);
        dx = div_tz(longint'(signed'(c.ox)) - org_x, den);
        dy = div_tz(longint'(signed'(c.oy)) - org_y, den);
        org_x = sat32(org_x + dx * den);
        org_y = sat32(org_y + dy * den);
        tmp_grid = grid_q;
        for (int y = 0; y < h; y++)
          for (int x = 0; x < w; x++) begin
            sx = x + dx;
            sy = y + dy;
            if (x + dx >= 0 && x + dx < w && y + dy >= 0 && y + dy < h)
              grid_q[y * MaxWidth + x] = tmp_grid[sy * MaxWidth + sx];
            else grid_q[y * MaxWidth + x] = def_q;
          end
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 1000000) begin
        $display("FAIL rolling_cost_grid");
        $finish;
      end
    end
  end

  // result side
  always @(posedge clk_i) begin
    res_t got, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[8:0];
      words_out <= words_out + 1;
      if (expected_q.size() == 0) begin
        $error("unexpected result word %h", got);
        fails++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.cost !== exp_r.cost) begin
          $error("read_cost expected %0d actual %0d", exp_r.cost, got.cost);
          fails++;
        end
        if (got.oor !== exp_r.oor) begin
          $error("out_of_range expected %0d actual %0d", exp_r.oor, got.oor);
          fails++;
        end
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(input reg_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_WIDTH:  width_q = val[8:0];
      REG_HEIGHT: height_q = val[8:0];
      REG_RES:    res_q = val[30:0];
      default:    def_q = val[7:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_cmd(input cmd_t c, input logic chk, input res_t want);
    res_t r;
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, c};
    do @(posedge clk_i); while (!s_axis_tready);
    s_axis_tvalid <= 1'b0;
    predict_cost(c, r);
    if (chk && r !== want) begin
      $error("directed row: predicted %h, typed %h", r, want);
      fails++;
    end
    expected_q = {expected_q, r};
    if (c.op == OP_SHIFT) n_shift++;
    if (c.op == OP_CLEAR) n_clear++;
    @(posedge clk_i);
  endtask

  function automatic cmd_t mk(op_e op, int cx, int cy, int ex, int ey, int wc,
                              logic [31:0] ox, logic [31:0] oy);
    cmd_t c;
    c.op = op; c.cx = 8'(cx); c.cy = 8'(cy); c.ex = 9'(ex); c.ey = 9'(ey);
    c.wc = 8'(wc);
    c.ox = ox; c.oy = oy;
    return c;
  endfunction

  function automatic cmd_t rand_cmd(int w, int h);
    cmd_t c;
    int k;
    c = 108'({$urandom, $urandom, $urandom, $urandom});
    k = $urandom_range(99);
    c.op = k < 40 ? OP_WRITE : k < 80 ? OP_READ : k < 92 ? OP_CLEAR : OP_SHIFT;
    if ($urandom_range(9) > 0) begin
      c.cx = 8'($urandom_range(w - 1 > 255 ? 255 : w - 1));
      c.cy = 8'($urandom_range(h - 1 > 255 ? 255 : h - 1));
    end
    if (c.op == OP_CLEAR && $urandom_range(3) > 0) begin
      c.ex = 9'(c.cx + $urandom_range(6));
      c.ey = 9'(c.cy + $urandom_range(6));
    end
    if (c.op == OP_SHIFT && $urandom_range(3) > 0) begin
      c.ox = 32'(org_x + ($urandom_range(12) - 6) * longint'(res_q) + $urandom_range(3));
      c.oy = 32'(org_y + ($urandom_range(12) - 6) * longint'(res_q) - $urandom_range(3));
    end
    return c;
  endfunction

  row_t dir_rows[$];

  initial begin
    int w, h;
    grid_q = '{default: 8'd0};
    org_x = 0; org_y = 0;
    width_q = 9'd256; height_q = 9'd256; res_q = 31'd3277; def_q = 8'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table at reset sizes
    dir_rows = '{
      '{mk(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1, 9'h000},
      '{mk(OP_WRITE, 255, 255, 0, 0, 8'hff, 0, 0), 1, 9'h000},
      '{mk(OP_READ, 255, 255, 0, 0, 0, 0, 0), 1, 9'h0ff},
      '{mk(OP_WRITE, 0, 0, 0, 0, 8'h5a, 0, 0), 1, 9'h000},
      '{mk(OP_WRITE, 1, 0, 0, 0, 8'ha5, 0, 0), 1, 9'h000},
      '{mk(OP_CLEAR, 0, 0, 1, 1, 0, 0, 0), 1, 9'h000},
      '{mk(OP_READ, 1, 0, 0, 0, 0, 0, 0), 1, 9'h0a5},
      '{mk(OP_CLEAR, 3, 3, 2, 2, 0, 0, 0), 1, 9'h000},
      '{mk(OP_CLEAR, 254, 254, 257, 300, 0, 0, 0), 1, 9'h100},
      '{mk(OP_SHIFT, 0, 0, 0, 0, 0, 32'd3277, 32'd0), 0, 9'h0},
      '{mk(OP_SHIFT, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000), 0, 9'h0},
      '{mk(OP_SHIFT, 0, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff), 0, 9'h0},
      '{mk(OP_READ, 0, 0, 0, 0, 0, 0, 0), 0, 9'h0}
    };
    foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].chk, dir_rows[i].res);
    drain();

    // small grid, odd settings, out-of-range accesses
    write_reg(REG_WIDTH, 32'd5);
    write_reg(REG_HEIGHT, 32'd0);
    write_reg(REG_RES, 32'd0);
    write_reg(REG_DEF, 32'hff);
    send_cmd(mk(OP_WRITE, 5, 0, 0, 0, 1, 0, 0), 1, 9'h100);
    send_cmd(mk(OP_READ, 0, 1, 0, 0, 0, 0, 0), 1, 9'h100);
    send_cmd(mk(OP_WRITE, 4, 0, 0, 0, 8'h33, 0, 0), 1, 9'h000);
    send_cmd(mk(OP_SHIFT, 0, 0, 0, 0, 0, 32'hfffffffe, 0), 0, 9'h0);
    send_cmd(mk(OP_READ, 4, 0, 0, 0, 0, 0, 0), 0, 9'h0);
    send_cmd(mk(OP_CLEAR, 0, 0, 9'h1ff, 9'h1ff, 0, 0, 0), 1, 9'h100);
    drain();
    write_reg(REG_WIDTH, 32'h1ff);
    write_reg(REG_HEIGHT, 32'h1ff);
    write_reg(REG_RES, 32'h7fffffff);
    send_cmd(mk(OP_SHIFT, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000), 0, 9'h0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      drain();
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 16);
      if (phase == 7) begin w = 256; h = 256; end
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_RES, phase == 5 ? 1 : $urandom_range(1, 70000));
      write_reg(REG_DEF, $urandom_range(255));
      if (phase == 2) hold_off = 300;
      for (int i = 0; i < 112; i++) begin
        cmd_t c;
        c = rand_cmd(w, h);
        if (phase == 7 && c.op == OP_SHIFT) c.op = OP_READ;
        send_cmd(c, 0, '0);
      end
      // let every outstanding word arrive before the next phase
      drain();
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d result words, %0d shifts and %0d clears over several sizes",
             words_out, n_shift, n_clear);
    if (fails == 0 && expected_q.size() == 0) $display("PASS rolling_cost_grid");
    else $display("FAIL rolling_cost_grid");
    $finish;
  end
endmodule
